@@ rtl/cbfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cbfr_pkg
// Shared constants, the result item type and the response byte table of the
// call bell frame receiver.
// ----------------------------------------------------------------------------
package cbfr_pkg;

  // Default window depth in bytes.
  localparam int unsigned MAX_FRAME_LEN = 24;

  // Smallest window that can hold a header with its length and option.
  localparam int unsigned MIN_WINDOW = 6;
  localparam int unsigned HDR_BYTES  = 6;

  // Frame header and option codes.
  localparam logic [7:0]  HDR0        = 8'h03;
  localparam logic [7:0]  HDR1        = 8'h01;
  localparam logic [15:0] OPT_CONNECT = 16'hA501;
  localparam logic [15:0] OPT_BELL    = 16'hA505;
  // Option that is seen on the line but gets no response.
  localparam logic [15:0] OPT_IGNORED = 16'hA514;
  localparam int unsigned LEN_CONNECT = 12;
  localparam int unsigned LEN_BELL    = 20;

  // Response frame fields.
  localparam logic [7:0]  RESP_LEN     = 8'h08;
  localparam logic [7:0]  RESP_CMD     = 8'hC5;
  localparam logic [7:0]  CODE_CONNECT = 8'h01;
  localparam logic [7:0]  CODE_BELL    = 8'h05;
  localparam int unsigned RESP_BYTES   = 8;

  // Byte positions of the call event fields in a bell frame.
  localparam int unsigned BELL_ID_POS = 10;
  localparam int unsigned BUTTON_POS  = 14;
  localparam int unsigned KIND_POS    = 15;

  // Result item kinds.
  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // One result item as handed from the sequencer to the output register.
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [31:0] bell_id;
    logic [7:0]  button_code;
    logic [7:0]  bell_kind;
    logic        last;
  } res_t;

  // Byte idx of the 8-byte response frame for the given code. The final
  // byte is the two's-complement negation of the sum of the others.
  function automatic logic [7:0] resp_byte(input logic [2:0] idx, input logic [7:0] code);
    logic [7:0] r;
    case (idx)
      3'd0:    r = HDR0;
      3'd1:    r = HDR1;
      3'd2:    r = 8'h00;
      3'd3:    r = RESP_LEN;
      3'd4:    r = RESP_CMD;
      3'd5:    r = code;
      3'd6:    r = 8'h00;
      default: r = 8'h00 - (HDR0 + HDR1 + RESP_LEN + RESP_CMD + code);
    endcase
    return r;
  endfunction

endpackage

@@ rtl/call_bell_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// call_bell_frame_receiver
// Receives serial bytes, finds connect and bell frames and emits response
// bytes and call events.
// ----------------------------------------------------------------------------
// Each accepted byte is written into a circular window RAM and the window
// front is then scanned one byte per cycle through the RAM's single read
// port. After each accepted byte the sequencer makes a scan decision: with
// fewer than six bytes buffered it returns to idle, otherwise it reads the
// six header bytes and checks them. A bad header drops the front byte and
// the front is looked at again. A complete connect or bell frame goes
// through the checksum pass, then its result items are emitted, waiting
// while the output stalls, and the frame is removed before the front is
// looked at again. The input stalls for the whole of this work. The window
// needs no clearing pass after reset; only bytes below the fill count are
// read.
// ----------------------------------------------------------------------------
module call_bell_frame_receiver
  import cbfr_pkg::*;
#(
  parameter int unsigned MaxFrameLen = MAX_FRAME_LEN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received byte items.
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  // Result items.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [31:0] bell_id_o,
  output logic [7:0]  button_code_o,
  output logic [7:0]  bell_kind_o,
  output logic        last_o
);

  localparam int unsigned AddrW = $clog2(MaxFrameLen);

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  // Window buffer.
  cbfr_ram #(
    .Width (8),
    .Depth (MaxFrameLen)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer.
  cbfr_ctrl #(
    .MaxFrameLen (MaxFrameLen)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_valid_i),
    .in_byte_i   (rx_byte_i),
    .in_stall_o  (rx_stall_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register: loads when empty or when its item is taken.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_q.kind;
  assign tx_byte_o     = out_q.tx_byte;
  assign bell_id_o     = out_q.bell_id;
  assign button_code_o = out_q.button_code;
  assign bell_kind_o   = out_q.bell_kind;
  assign last_o        = out_q.last;

endmodule

@@ rtl/cbfr_ram.sv @@
// ----------------------------------------------------------------------------
// cbfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cbfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 24,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cbfr_sum.sv @@
// ----------------------------------------------------------------------------
// cbfr_sum
// Checksum accumulator: adds one frame byte per cycle while add_i is high,
// modulo 256, and offers the two's-complement negation of the running sum.
// ----------------------------------------------------------------------------
module cbfr_sum (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clr_i,
  input  logic       add_i,
  input  logic [7:0] byte_i,
  output logic [7:0] neg_o
);

  logic [7:0] acc_q, acc_d;

  // Clear has priority over accumulate.
  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = 8'h00;
    end else if (add_i) begin
      acc_d = acc_q + byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 8'h00;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign neg_o = 8'h00 - acc_q;

endmodule

@@ rtl/cbfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbfr_ctrl
// Window sequencer: appends received bytes to the circular window, scans
// the front for a valid header, checks complete frames one byte a cycle and
// produces the response and call event items.
// ----------------------------------------------------------------------------
module cbfr_ctrl
  import cbfr_pkg::*;
#(
  parameter int unsigned MaxFrameLen = MAX_FRAME_LEN,
  localparam int unsigned AddrW = $clog2(MaxFrameLen),
  localparam int unsigned CntW  = $clog2(MaxFrameLen + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input item channel.
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  output logic             in_stall_o,
  // Window RAM.
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [7:0]       ram_wdata_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [7:0]       ram_rdata_i,
  // Result items toward the output register.
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             res_ready_i
);

  localparam int unsigned SumW = $clog2(2 * MaxFrameLen);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_HDR   = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_SUM   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_DROP  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_i_q, rd_i_d;
  logic             cap_v_q, cap_v_d;
  logic [CntW-1:0]  cap_i_q, cap_i_d;
  logic [CntW-1:0]  len_q, len_d;
  logic             is_bell_q, is_bell_d;
  logic [3:0]       emit_i_q, emit_i_d;
  logic [7:0]       hdr_q [HDR_BYTES];
  logic [7:0]       hdr_d [HDR_BYTES];
  logic [31:0]      bell_id_q, bell_id_d;
  logic [7:0]       button_q, button_d;
  logic [7:0]       bkind_q, bkind_d;

  logic [CntW-1:0]  ptr_off;
  logic [SumW-1:0]  ptr_sum;
  logic [AddrW-1:0] ptr_wrap;
  logic             full;
  logic [CntW-1:0]  n_rd;
  logic [CntW-1:0]  last_idx;
  logic [15:0]      len16;
  logic [15:0]      opt16;
  logic             hdr_ok;
  logic             sum_clr;
  logic             sum_add;
  logic [7:0]       neg_sum;

  // Shared pointer adder: head plus an offset, wrapped into the window.
  assign ptr_sum  = SumW'(head_q) + SumW'(ptr_off);
  assign ptr_wrap = (ptr_sum >= SumW'(MaxFrameLen)) ?
                    AddrW'(ptr_sum - SumW'(MaxFrameLen)) : AddrW'(ptr_sum);

  assign full     = (count_q == CntW'(MaxFrameLen));
  assign n_rd     = (state_q == ST_HDR) ? CntW'(HDR_BYTES) : len_q;
  assign last_idx = len_q - CntW'(1);

  // Header fields of the window front.
  assign len16  = {hdr_q[2], hdr_q[3]};
  assign opt16  = {hdr_q[4], hdr_q[5]};
  assign hdr_ok = (hdr_q[0] == HDR0) && (hdr_q[1] == HDR1) && !len16[15] &&
                  (len16 != 16'd0) && (len16 <= 16'(MaxFrameLen));

  // Offset selection for the pointer adder.
  always_comb begin
    case (state_q)
      ST_IDLE:  ptr_off = full ? CntW'(1) : count_q;
      ST_CHECK: ptr_off = CntW'(1);
      ST_DROP:  ptr_off = len_q;
      default:  ptr_off = rd_i_q;
    endcase
  end

  // Checksum unit: cleared before the pass, fed every byte but the last.
  assign sum_clr = (state_q == ST_CHECK);
  assign sum_add = (state_q == ST_SUM) && cap_v_q && (cap_i_q != last_idx);

  cbfr_sum u_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (sum_clr),
    .add_i  (sum_add),
    .byte_i (ram_rdata_i),
    .neg_o  (neg_sum)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign ram_wdata_o = in_byte_i;
  assign ram_raddr_o = ptr_wrap;

  // Result item under construction.
  always_comb begin
    res_o = '0;
    if (emit_i_q < 4'(RESP_BYTES)) begin
      res_o.kind    = KIND_TX;
      res_o.tx_byte = resp_byte(emit_i_q[2:0], is_bell_q ? CODE_BELL : CODE_CONNECT);
      res_o.last    = !is_bell_q && (emit_i_q == 4'(RESP_BYTES - 1));
    end else begin
      res_o.kind        = KIND_EVENT;
      res_o.bell_id     = bell_id_q;
      res_o.button_code = button_q;
      res_o.bell_kind   = bkind_q;
      res_o.last        = 1'b1;
    end
  end

  assign res_valid_o = (state_q == ST_EMIT);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    rd_i_d    = rd_i_q;
    cap_v_d   = 1'b0;
    cap_i_d   = cap_i_q;
    len_d     = len_q;
    is_bell_d = is_bell_q;
    emit_i_d  = emit_i_q;
    hdr_d     = hdr_q;
    bell_id_d = bell_id_q;
    button_d  = button_q;
    bkind_d   = bkind_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = ptr_wrap;

    // Read issue for the header and checksum passes.
    if ((state_q == ST_HDR || state_q == ST_SUM) && (rd_i_q < n_rd)) begin
      rd_i_d  = rd_i_q + CntW'(1);
      cap_v_d = 1'b1;
      cap_i_d = rd_i_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ram_we_o = 1'b1;
          if (full) begin
            // Overwrite the oldest byte and advance the front.
            ram_waddr_o = head_q;
            head_d      = ptr_wrap;
          end else begin
            count_d = count_q + CntW'(1);
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (count_q < CntW'(MIN_WINDOW)) begin
          state_d = ST_IDLE;
        end else begin
          rd_i_d  = '0;
          state_d = ST_HDR;
        end
      end
      ST_HDR: begin
        if (cap_v_q) begin
          for (int k = 0; k < HDR_BYTES; k++) begin
            if (cap_i_q == CntW'(k)) begin
              hdr_d[k] = ram_rdata_i;
            end
          end
          if (cap_i_q == CntW'(HDR_BYTES - 1)) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!hdr_ok) begin
          // Drop the front byte and rescan.
          head_d  = ptr_wrap;
          count_d = count_q - CntW'(1);
          state_d = ST_SCAN;
        end else if (len16 > 16'(count_q)) begin
          state_d = ST_IDLE;
        end else begin
          len_d = len16[CntW-1:0];
          if (opt16 == OPT_CONNECT && len16 == 16'(LEN_CONNECT)) begin
            is_bell_d = 1'b0;
            rd_i_d    = '0;
            state_d   = ST_SUM;
          end else if (opt16 == OPT_BELL && len16 == 16'(LEN_BELL)) begin
            is_bell_d = 1'b1;
            rd_i_d    = '0;
            state_d   = ST_SUM;
          end else begin
            state_d = ST_DROP;
          end
        end
      end
      ST_SUM: begin
        if (cap_v_q) begin
          if (cap_i_q == CntW'(BELL_ID_POS)) bell_id_d[31:24] = ram_rdata_i;
          if (cap_i_q == CntW'(BELL_ID_POS + 1)) bell_id_d[23:16] = ram_rdata_i;
          if (cap_i_q == CntW'(BELL_ID_POS + 2)) bell_id_d[15:8] = ram_rdata_i;
          if (cap_i_q == CntW'(BELL_ID_POS + 3)) bell_id_d[7:0] = ram_rdata_i;
          if (cap_i_q == CntW'(BUTTON_POS)) button_d = ram_rdata_i;
          if (cap_i_q == CntW'(KIND_POS)) bkind_d = ram_rdata_i;
          if (cap_i_q == last_idx) begin
            emit_i_d = '0;
            state_d  = (ram_rdata_i == neg_sum) ? ST_EMIT : ST_DROP;
          end
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          if (res_o.last) begin
            state_d = ST_DROP;
          end else begin
            emit_i_d = emit_i_q + 4'd1;
          end
        end
      end
      ST_DROP: begin
        // Remove the whole frame from the window front.
        head_d  = ptr_wrap;
        count_d = count_q - len_q;
        state_d = ST_SCAN;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      rd_i_q  <= '0;
      cap_v_q <= 1'b0;
      cap_i_q <= '0;
      len_q   <= '0;
      is_bell_q <= 1'b0;
      emit_i_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      rd_i_q  <= rd_i_d;
      cap_v_q <= cap_v_d;
      cap_i_q <= cap_i_d;
      len_q   <= len_d;
      is_bell_q <= is_bell_d;
      emit_i_q  <= emit_i_d;
    end
  end

  // Captured frame bytes.
  always_ff @(posedge clk_i) begin
    hdr_q     <= hdr_d;
    bell_id_q <= bell_id_d;
    button_q  <= button_d;
    bkind_q   <= bkind_d;
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Call bell frame receiver testbench
// Feeds serial byte items into the frame receiver and checks every response
// byte and call event against a behavioral predictor that runs alongside.
// Directed frames cover connect and bell frames and malformed headers. The
// random part mixes good frames, corrupted frames and line noise, while the
// sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb
  import cbfr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned IDLE_LIMIT   = 4000;
  // Cycles allowed after the last result for work that produces nothing.
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned RANDOM_BYTES = 200;
  // Length of the long output hold-off.
  localparam int unsigned HOLD_CYCLES  = 600;

  logic        clk;
  logic        rst_n;
  logic        rx_valid;
  logic        rx_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [7:0]  tx_byte;
  logic [31:0] bell_id;
  logic [7:0]  button_code;
  logic [7:0]  bell_kind;
  logic        last;

  // Predictor state: a copy of the receive window.
  logic [7:0]  win_q [MAX_FRAME_LEN];
  int          win_cnt;

  // Results still owed by the block, oldest first.
  res_t        owed_q [$];
  // Bytes of the frame being assembled for sending.
  logic [7:0]  frame_q [$];

  int          err_cnt;
  int          idle_cycles;
  bit          hold_req;
  int          burst_left;
  int          bytes_sent;
  bit          gaps_on;

  call_bell_frame_receiver u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .rx_valid_i    (rx_valid),
    .rx_stall_o    (rx_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_kind_o    (out_kind),
    .tx_byte_o     (tx_byte),
    .bell_id_o     (bell_id),
    .button_code_o (button_code),
    .bell_kind_o   (bell_kind),
    .last_o        (last)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor: remove bytes from the front of the window.
  task automatic drop_front(input int n);
    int i;
    if (n >= win_cnt) begin
      win_cnt = 0;
    end else begin
      for (i = 0; i < win_cnt - n; i++) begin
        win_q[i] = win_q[i + n];
      end
      win_cnt -= n;
    end
  endtask

  // Negated byte sum of the first n window bytes.
  function automatic logic [7:0] window_neg_sum(input int n);
    logic [7:0] sum;
    int i;
    sum = 8'h00;
    for (i = 0; i < n; i++) begin
      sum += win_q[i];
    end
    return 8'h00 - sum;
  endfunction

  // Predictor: take one received byte and queue the results it causes.
  task automatic predict_byte(input logic [7:0] b);
    res_t       found [$];
    res_t       r;
    logic [7:0] resp [8];
    logic [7:0] sum;
    logic [7:0] code;
    logic [15:0] opt;
    bit         ok;
    int         len;
    int         i;
    if (win_cnt >= MAX_FRAME_LEN) begin
      drop_front(1);
    end
    win_q[win_cnt] = b;
    win_cnt++;
    while (win_cnt > 5) begin
      if (win_q[0] != HDR0 || win_q[1] != HDR1) begin
        drop_front(1);
        continue;
      end
      // The length field is a signed 16-bit big-endian value.
      len = int'($signed({win_q[2], win_q[3]}));
      if (len <= 0 || len > int'(MAX_FRAME_LEN)) begin
        drop_front(1);
        continue;
      end
      if (len > win_cnt) begin
        break;
      end
      opt  = {win_q[4], win_q[5]};
      ok   = 1'b0;
      code = CODE_CONNECT;
      if (opt == OPT_CONNECT && len == int'(LEN_CONNECT)) begin
        ok = (win_q[LEN_CONNECT - 1] == window_neg_sum(LEN_CONNECT - 1));
      end else if (opt == OPT_BELL && len == int'(LEN_BELL)) begin
        ok   = (win_q[LEN_BELL - 1] == window_neg_sum(LEN_BELL - 1));
        code = CODE_BELL;
      end
      if (ok) begin
        resp = '{HDR0, HDR1, 8'h00, RESP_LEN, RESP_CMD, code, 8'h00, 8'h00};
        sum  = 8'h00;
        for (i = 0; i < 7; i++) begin
          sum += resp[i];
        end
        resp[7] = 8'h00 - sum;
        for (i = 0; i < 8; i++) begin
          r         = '0;
          r.kind    = KIND_TX;
          r.tx_byte = resp[i];
          found     = {found, r};
        end
        // A bell frame also raises a call event.
        if (code == CODE_BELL) begin
          r             = '0;
          r.kind        = KIND_EVENT;
          r.bell_id     = {win_q[BELL_ID_POS], win_q[BELL_ID_POS + 1],
                           win_q[BELL_ID_POS + 2], win_q[BELL_ID_POS + 3]};
          r.button_code = win_q[BUTTON_POS];
          r.bell_kind   = win_q[KIND_POS];
          found         = {found, r};
        end
      end
      drop_front(len);
    end
    if (found.size() > 0) begin
      r                       = found[found.size() - 1];
      r.last                  = 1'b1;
      found[found.size() - 1] = r;
    end
    owed_q = {owed_q, found};
  endtask

  // Send one byte item, with burst and gap idling when enabled.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 10);
        repeat (gap) begin
          @(negedge clk);
          rx_valid <= 1'b0;
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do begin
      @(posedge clk);
    end while (rx_stall);
    predict_byte(b);
    bytes_sent++;
  endtask

  // Frame assembly helpers.
  task automatic put_byte(input logic [7:0] b);
    frame_q = {frame_q, b};
  endtask

  task automatic put_header(input logic [15:0] len, input logic [15:0] opt);
    put_byte(HDR0);
    put_byte(HDR1);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    put_byte(opt[15:8]);
    put_byte(opt[7:0]);
  endtask

  task automatic put_random(input int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  task automatic put_word(input logic [31:0] w);
    put_byte(w[31:24]);
    put_byte(w[23:16]);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  // Append the checksum byte; a bad one is off by a nonzero amount.
  task automatic put_checksum(input bit bad);
    logic [7:0] sum;
    sum = 8'h00;
    foreach (frame_q[i]) begin
      sum += frame_q[i];
    end
    put_byte(8'h00 - sum + (bad ? 8'($urandom_range(1, 255)) : 8'h00));
  endtask

  task automatic send_frame();
    while (frame_q.size() > 0) begin
      send_byte(frame_q.pop_front());
    end
  endtask

  task automatic send_connect(input bit bad);
    put_header(16'(LEN_CONNECT), OPT_CONNECT);
    put_random(5);
    put_checksum(bad);
    send_frame();
  endtask

  task automatic send_bell(input logic [31:0] id, input logic [7:0] button,
                           input logic [7:0] kind, input bit bad);
    put_header(16'(LEN_BELL), OPT_BELL);
    put_random(4);
    put_word(id);
    put_byte(button);
    put_byte(kind);
    put_random(3);
    put_checksum(bad);
    send_frame();
  endtask

  // A random frame; output only if it forms a valid connect or bell frame.
  task automatic send_other_frame();
    logic [15:0] opt;
    int          len;
    len = $urandom_range(1, MAX_FRAME_LEN);
    case ($urandom_range(0, 3))
      0:       opt = OPT_IGNORED;
      1:       opt = OPT_CONNECT;
      2:       opt = OPT_BELL;
      default: opt = 16'($urandom);
    endcase
    put_header(16'(len), opt);
    put_random(len > 6 ? len - 6 : 0);
    send_frame();
  endtask

  // Line noise: a header with an illegal length, or random bytes.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0:       put_header(16'h0000, 16'($urandom));
      1:       put_header(16'h8000 | 16'($urandom), 16'($urandom));
      2:       put_header(16'($urandom_range(MAX_FRAME_LEN + 1, 16'h7FFF)), 16'($urandom));
      default: put_random($urandom_range(1, 6));
    endcase
    send_frame();
  endtask

  // Connect frames with plain and extreme content.
  task automatic test_connect();
    gaps_on = 1'b0;
    send_connect(1'b0);
    put_header(16'(LEN_CONNECT), OPT_CONNECT);
    put_word(32'hFFFF_FFFF);
    put_byte(8'hFF);
    put_checksum(1'b0);
    send_frame();
  endtask

  // Bell frames carrying the extreme event field values.
  task automatic test_bell();
    gaps_on = 1'b0;
    send_bell(32'hFFFF_FFFF, 8'hFF, 8'h00, 1'b0);
    send_bell(32'h0000_0000, 8'h00, 8'hFF, 1'b0);
  endtask

  // Malformed headers, a short frame and a frame with an unknown option.
  task automatic test_bad_headers();
    gaps_on = 1'b0;
    frame_q = '{8'h00, 8'hFF};
    put_header(16'h0000, OPT_CONNECT);
    put_header(16'h8000, OPT_BELL);
    put_header(16'(MAX_FRAME_LEN + 1), OPT_CONNECT);
    put_header(16'h0003, OPT_IGNORED);
    put_header(16'h0006, OPT_IGNORED);
    send_frame();
  endtask

  // Mostly well-formed frames with random content, mixed with corruption and noise.
  task automatic test_random();
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 35) begin
        send_bell($urandom, 8'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 60) begin
        send_connect(1'b0);
      end else if (pick < 68) begin
        send_bell($urandom, 8'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 74) begin
        send_connect(1'b1);
      end else if (pick < 85) begin
        send_other_frame();
      end else begin
        send_noise();
      end
    end
  endtask

  // Long output hold-off while frames keep arriving, so the input backs up.
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_bell($urandom, 8'($urandom), 8'($urandom), 1'b0);
    send_connect(1'b0);
    send_bell($urandom, 8'($urandom), 8'($urandom), 1'b0);
  endtask

  // Stimulus sequence and end of run.
  initial begin
    rst_n      = 1'b0;
    rx_valid   = 1'b0;
    rx_byte    = 8'h00;
    win_cnt    = 0;
    err_cnt    = 0;
    hold_req   = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    gaps_on    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_connect();
    test_bell();
    test_bad_headers();
    test_random();
    test_backpressure();

    @(negedge clk);
    rx_valid <= 1'b0;
    while (owed_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result stall pattern: cycles through no stall, random and periodic modes,
  // and holds off once for a long stretch when that is requested.
  initial begin : result_stall_gen
    int unsigned cyc;
    int unsigned mode;
    int unsigned held;
    cyc       = 0;
    held      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req && held < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        held++;
      end else begin
        mode = (cyc / 64) % 4;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= (cyc % 3 == 0);
          default: out_stall <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Compare one result field with its expected value.
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Check each accepted result item against the oldest owed result.
  always @(posedge clk) begin : result_check
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %b tx %h id %h",
                 $realtime, out_kind, tx_byte, bell_id);
        err_cnt++;
      end else begin
        e = owed_q.pop_front();
        check_field("out_kind", 32'(e.kind), 32'(out_kind));
        check_field("tx_byte", 32'(e.tx_byte), 32'(tx_byte));
        check_field("bell_id", e.bell_id, bell_id);
        check_field("button_code", 32'(e.button_code), 32'(button_code));
        check_field("bell_kind", 32'(e.bell_kind), 32'(bell_kind));
        check_field("last", 32'(e.last), 32'(last));
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((rx_valid && !rx_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no item accepted for %0d cycles", $realtime, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

@@ call_bell_frame_receiver.f @@
rtl/cbfr_pkg.sv
rtl/cbfr_ram.sv
rtl/cbfr_sum.sv
rtl/cbfr_ctrl.sv
rtl/call_bell_frame_receiver.sv
tb/sv/tb.sv
